>>> rtl/lic_pkg.sv
// ----------------------------------------------------------------------------
// lic_pkg: shared types and constants of the leading indent converter
// Holds the word formats of both channels, the job handed from the front end
// to the emitter, the emitter state codes and the character constants.
// ----------------------------------------------------------------------------
package lic_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Configuration register indexes.
  localparam logic CFG_TARGET_MODE = 1'b0;
  localparam logic CFG_TAB_WIDTH   = 1'b1;

  localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } lic_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } lic_out_t;

  // Work for one accepted byte: some indent units, then maybe the byte itself.
  typedef struct packed {
    logic [1:0] units;
    logic       has_byte;
    logic [7:0] data;
    logic       eot;
    logic       space_mode;
  } lic_job_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_UNIT,
    EM_BYTE
  } lic_em_state_t;

endpackage

>>> rtl/lic_emitter.sv
// ----------------------------------------------------------------------------
// lic_emitter: output sequencer of the leading indent converter
// Sends one job a word per cycle unless stalled: each indent unit as a tab or
// a run of spaces counted by a shared counter, then the passed byte, if any.
// ----------------------------------------------------------------------------
module lic_emitter #(
  parameter int MAX_TAB_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  lic_pkg::lic_job_t                   job,
  input  logic [$clog2(MAX_TAB_WIDTH+1)-1:0]  width,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lic_pkg::lic_out_t                   out_data
);
  import lic_pkg::*;

  localparam int WW = $clog2(MAX_TAB_WIDTH + 1);
  localparam int PW = $clog2(MAX_TAB_WIDTH);

  lic_em_state_t  state, state_next;
  lic_job_t       job_q, job_next;
  logic [1:0]     units_left, units_left_next;
  logic [PW-1:0]  space_cnt, space_cnt_next;
  logic           out_valid_next;
  lic_out_t       out_data_next;

  logic           load_ok;
  logic           unit_done;
  logic           emit;
  lic_out_t       emit_word;

  assign load_ok   = !out_valid || !out_stall;
  assign unit_done = !job_q.space_mode || ((WW'(space_cnt) + WW'(1)) == width);
  assign busy      = (state != EM_IDLE);

  // Next state and sequencer counters.
  always_comb begin
    state_next      = state;
    job_next        = job_q;
    units_left_next = units_left;
    space_cnt_next  = space_cnt;
    case (state)
      EM_IDLE: begin
        if (start) begin
          job_next        = job;
          units_left_next = job.units;
          space_cnt_next  = '0;
          state_next      = (job.units != 2'd0) ? EM_UNIT : EM_BYTE;
        end
      end
      EM_UNIT: begin
        if (load_ok) begin
          if (unit_done) begin
            space_cnt_next  = '0;
            units_left_next = units_left - 2'd1;
            if (units_left == 2'd1) begin
              state_next = job_q.has_byte ? EM_BYTE : EM_IDLE;
            end
          end else begin
            space_cnt_next = space_cnt + PW'(1);
          end
        end
      end
      EM_BYTE: begin
        if (load_ok) begin
          state_next = EM_IDLE;
        end
      end
      default: begin
        state_next = EM_IDLE;
      end
    endcase
  end

  // Word handed to the output register.
  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    case (state)
      EM_UNIT: begin
        emit               = load_ok;
        emit_word.out_byte = job_q.space_mode ? CH_SPACE : CH_TAB;
        emit_word.run_last = unit_done && (units_left == 2'd1) && !job_q.has_byte;
      end
      EM_BYTE: begin
        emit               = load_ok;
        emit_word.out_byte = job_q.data;
        emit_word.run_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit_word.text_done = emit_word.run_last && job_q.eot;
  end

  always_comb begin
    out_data_next  = emit ? emit_word : out_data;
    out_valid_next = emit || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    job_q      <= job_next;
    units_left <= units_left_next;
    space_cnt  <= space_cnt_next;
    out_data   <= out_data_next;
  end

endmodule

>>> rtl/leading_indent_converter_unit.sv
// Each accepted byte is first classified; its output words then pass one by one
// through the emitter counter, and a space that only extends a partial run gives
// no words. The single emit sequencer takes no new byte until it has sent every
// word of the last one, and it waits while the output is stalled.
// Reset (synchronous): line start, no pending spaces, tab mode, tab width 4.
// ----------------------------------------------------------------------------
// leading_indent_converter_unit: rewrites leading whitespace of text lines
// Counts leading spaces into indent units and hands each byte's words to the
// emitter, which writes a unit as one tab or as a run of spaces.
// ----------------------------------------------------------------------------
module leading_indent_converter_unit #(
  parameter int MAX_TAB_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lic_pkg::lic_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lic_pkg::lic_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata
);
  import lic_pkg::*;

  localparam int WW = $clog2(MAX_TAB_WIDTH + 1);
  localparam int PW = $clog2(MAX_TAB_WIDTH);
  localparam int CW = (WW > 5) ? WW : 5;

  logic           target_mode;
  logic [4:0]     tab_width;
  logic           in_indent, in_indent_next;
  logic [PW-1:0]  pending, pending_next;

  logic [WW-1:0]  width;
  logic [WW-1:0]  pending_inc;
  logic           in_acc;
  logic           busy;
  logic           start;
  lic_job_t       job;

  // Clamp the tab width into 1..MAX_TAB_WIDTH.
  always_comb begin
    if (tab_width == 5'd0) begin
      width = WW'(1);
    end else if (CW'(tab_width) > CW'(MAX_TAB_WIDTH)) begin
      width = WW'(MAX_TAB_WIDTH);
    end else begin
      width = WW'(tab_width);
    end
  end

  assign in_stall    = busy;
  assign in_acc      = in_valid && !in_stall;
  assign pending_inc = WW'(pending) + WW'(1);

  always_comb begin
    job            = '0;
    job.data       = in_data.text_byte;
    job.eot        = in_data.end_of_text;
    job.space_mode = target_mode;
    in_indent_next = in_indent;
    pending_next   = '0;
    if (!in_indent) begin
      job.has_byte   = 1'b1;
      in_indent_next = (in_data.text_byte == CH_NL);
    end else if (in_data.text_byte == CH_SPACE) begin
      if (pending_inc >= width) begin
        job.units = 2'd1;
      end else begin
        pending_next = PW'(pending_inc);
        // A partial run cut off by the end of text rounds up to one unit.
        if (in_data.end_of_text) begin
          job.units = 2'd1;
        end
      end
    end else if (in_data.text_byte == CH_TAB) begin
      job.units = (pending != '0) ? 2'd2 : 2'd1;
    end else begin
      job.units      = (pending != '0) ? 2'd1 : 2'd0;
      job.has_byte   = 1'b1;
      in_indent_next = (in_data.text_byte == CH_NL);
    end
    if (in_data.end_of_text) begin
      in_indent_next = 1'b1;
      pending_next   = '0;
    end
  end

  assign start = in_acc && ((job.units != 2'd0) || job.has_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_mode <= 1'b0;
      tab_width   <= TAB_WIDTH_RESET;
      in_indent   <= 1'b1;
      pending     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_MODE: target_mode <= cfg_wdata[0];
          CFG_TAB_WIDTH:   tab_width   <= cfg_wdata;
          default:         tab_width   <= tab_width;
        endcase
      end
      if (in_acc) begin
        in_indent <= in_indent_next;
        pending   <= pending_next;
      end
    end
  end

  lic_emitter #(
    .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .job       (job),
    .width     (width),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Spaces are only ever pending while inside the indentation.
  assert property (@(posedge clk) disable iff (rst) !in_indent |-> (pending == '0))
    else $error("pending spaces outside indentation");

  // The end of the text returns the line state to its start.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.end_of_text) |=> (in_indent && (pending == '0)))
    else $error("line state not reset after end of text");

  // A new job never reaches a busy emitter.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("job started while emitter busy");

  // The final word of a text is also the last word of its byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.text_done) |-> out_data.run_last)
    else $error("text_done without run_last");

endmodule
